// ===== hw/rtl/timing_redundancy_controller_core_assert.svh =====
// Assertion macros shared by the timing redundancy controller RTL.
`ifndef TIMING_REDUNDANCY_CONTROLLER_CORE_ASSERT_SVH
`define TIMING_REDUNDANCY_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define TRC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trc: same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define TRC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trc: next-cycle check failed");

`endif

// ===== hw/rtl/trc_pkg.sv =====
// Package with types, codes and constants of the timing redundancy controller.
`default_nettype none
package trc_pkg;

  localparam int TRC_TIMER_BITS = 16;

  localparam logic [15:0] TRC_TIMEOUT_RESET = 16'(5 * 1000);
  localparam logic [15:0] TRC_HOLDOFF_RESET = 16'(30 * 1000);

  // Request kinds
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // Configured mode
  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_MASTER = 2'd1;
  localparam logic [1:0] MODE_SLAVE  = 2'd2;

  // Mate clock mode
  localparam logic [1:0] MCM_MASTER = 2'd0;
  localparam logic [1:0] MCM_SLAVE  = 2'd1;
  localparam logic [1:0] MCM_HOLD   = 2'd2;

  // Clock mode commands
  localparam logic [1:0] CM_NONE   = 2'd0;
  localparam logic [1:0] CM_MASTER = 2'd1;
  localparam logic [1:0] CM_SLAVE  = 2'd2;
  localparam logic [1:0] CM_HOLD   = 2'd3;

  // Auto switch commands
  localparam logic [1:0] AS_NONE    = 2'd0;
  localparam logic [1:0] AS_ENABLE  = 2'd1;
  localparam logic [1:0] AS_DISABLE = 2'd2;

  // Control flag writes
  localparam logic [1:0] CT_NONE = 2'd0;
  localparam logic [1:0] CT_INSV = 2'd1;
  localparam logic [1:0] CT_OOS  = 2'd2;

  // Announcements
  localparam logic [1:0] AN_NONE   = 2'd0;
  localparam logic [1:0] AN_SLAVE  = 2'd1;
  localparam logic [1:0] AN_MASTER = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_HOLDOFF  = 2'd1;
  localparam logic [1:0] REG_SW_ON_TO = 2'd2;
  localparam logic [1:0] REG_AUTO_UPD = 2'd3;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] holdoff_ticks;
    logic        switch_on_timeout;
    logic        auto_update;
  } cfg_t;

  typedef struct packed {
    logic       operation;
    logic [1:0] configured_mode;
    logic       switch_required;
    logic       config_changed;
    logic       card_in_service;
    logic       is_master;
    logic       mate_is_master;
    logic       mate_ready;
    logic       mate_present;
    logic [1:0] mate_clock_mode;
    logic       local_mode_slave;
  } item_t;

  typedef struct packed {
    logic [1:0] fsm_state;
    logic [1:0] clock_mode_cmd;
    logic [1:0] auto_switch_cmd;
    logic [1:0] control_cmd;
    logic       acquire_mastership;
    logic       release_mastership;
    logic [1:0] announce;
    logic       read_tx_ssm;
    logic       mode_notify;
  } result_t;

endpackage
`default_nettype wire

// ===== hw/rtl/trc_cfg.sv =====
// Configuration register bank of the timing redundancy controller.
`default_nettype none
module trc_cfg
  import trc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire logic [1:0]  wr_index,
  input  wire logic [15:0] wr_data,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks     <= TRC_TIMEOUT_RESET;
      cfg.holdoff_ticks     <= TRC_HOLDOFF_RESET;
      cfg.switch_on_timeout <= 1'b1;
      cfg.auto_update       <= 1'b0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TIMEOUT:  cfg.timeout_ticks     <= wr_data;
        REG_HOLDOFF:  cfg.holdoff_ticks     <= wr_data;
        REG_SW_ON_TO: cfg.switch_on_timeout <= wr_data[0];
        REG_AUTO_UPD: cfg.auto_update       <= wr_data[0];
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/trc_fsm.sv =====
// Redundancy state machine with holdover timers; one request per enabled cycle.
`default_nettype none
`include "timing_redundancy_controller_core_assert.svh"
module trc_fsm
  import trc_pkg::*;
#(
  parameter int TIMER_BITS = TRC_TIMER_BITS
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  step_en,
  input  wire item_t item,
  input  wire cfg_t  cfg,
  output result_t    res
);

  typedef enum logic [1:0] {
    ST_INIT   = 2'd0,
    ST_MASTER = 2'd1,
    ST_SLAVE  = 2'd2,
    ST_HOLD   = 2'd3
  } state_t;

  localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
  localparam logic [TIMER_BITS-1:0] CNT_MAX = '1;
  localparam logic [TIMER_BITS-1:0] CNT_ONE = TIMER_BITS'(1);

  state_t                state, state_next;
  logic [TIMER_BITS-1:0] to_cnt, to_cnt_next, ho_cnt, ho_cnt_next;
  logic                  to_run, to_run_next, ho_run, ho_run_next;
  logic                  ctl_oos, ctl_oos_next;
  logic                  move;
  logic                  to_exp, ho_exp, cfg_master, cfg_slave, sot;

  assign cfg_master = (item.configured_mode == MODE_MASTER);
  assign cfg_slave  = (item.configured_mode == MODE_SLAVE);
  assign sot        = cfg.switch_on_timeout;
  assign to_exp     = to_run && (CW'(to_cnt) >= CW'(cfg.timeout_ticks));
  assign ho_exp     = ho_run && (CW'(ho_cnt) >= CW'(cfg.holdoff_ticks));

  always_comb begin
    res          = '0;
    move         = 1'b0;
    state_next   = state;
    to_cnt_next  = to_cnt;
    ho_cnt_next  = ho_cnt;
    to_run_next  = to_run;
    ho_run_next  = ho_run;
    ctl_oos_next = ctl_oos;

    if (item.operation == OP_TICK) begin
      if (to_run && to_cnt != CNT_MAX) to_cnt_next = to_cnt + CNT_ONE;
      if (ho_run && ho_cnt != CNT_MAX) ho_cnt_next = ho_cnt + CNT_ONE;
    end else begin
      unique case (state)
        ST_INIT: begin
          priority if (cfg_master) begin
            move = 1'b1; state_next = ST_MASTER;
          end else if (cfg_slave) begin
            move = 1'b1; state_next = ST_SLAVE;
          end else if (sot) begin
            if (item.card_in_service) begin
              res.acquire_mastership = 1'b1;
              ctl_oos_next = 1'b0;
              res.control_cmd = CT_INSV;
            end else begin
              ctl_oos_next = 1'b1;
              res.control_cmd = CT_OOS;
            end
            res.clock_mode_cmd = CM_HOLD;
            move = 1'b1; state_next = ST_HOLD;
          end else begin
            ctl_oos_next    = !item.card_in_service;
            res.control_cmd = item.card_in_service ? CT_INSV : CT_OOS;
            if (item.local_mode_slave) begin
              if (item.mate_ready) begin
                res.release_mastership = 1'b1;
                move = 1'b1; state_next = ST_SLAVE;
              end else begin
                res.announce = AN_SLAVE;
              end
            end else begin
              if (item.mate_ready) begin
                res.acquire_mastership = 1'b1;
                move = 1'b1;
                state_next = item.is_master ? ST_MASTER : ST_SLAVE;
              end else begin
                res.announce = AN_MASTER;
              end
            end
          end
        end
        ST_MASTER: begin
          res.read_tx_ssm = 1'b1;
          if (!cfg_master && (item.switch_required || item.config_changed)) begin
            move = 1'b1; state_next = ST_HOLD;
          end
        end
        ST_SLAVE: begin
          res.read_tx_ssm = 1'b1;
          if (!cfg_slave) begin
            if (item.card_in_service) begin
              res.auto_switch_cmd = AS_ENABLE;
              if (ctl_oos) begin
                ctl_oos_next = 1'b0;
                res.control_cmd = CT_INSV;
              end
              if ((!item.is_master || item.config_changed) && !item.mate_is_master &&
                  item.mate_ready)
                res.acquire_mastership = 1'b1;
              if (item.is_master) begin
                move = 1'b1; state_next = ST_HOLD;
              end else begin
                res.clock_mode_cmd = CM_SLAVE;
              end
            end else begin
              res.auto_switch_cmd = AS_DISABLE;
            end
          end
        end
        ST_HOLD: begin
          if (item.is_master) begin
            if ((sot && to_exp) || (sot && item.mate_clock_mode == MCM_SLAVE) ||
                (!sot && ho_exp && item.mate_clock_mode == MCM_SLAVE) ||
                cfg_master || !item.mate_present) begin
              move = 1'b1; state_next = ST_MASTER;
            end
          end else begin
            if ((sot && to_exp) || item.mate_clock_mode == MCM_MASTER ||
                item.mate_clock_mode == MCM_HOLD || cfg_slave || !item.mate_present) begin
              move = 1'b1; state_next = ST_SLAVE;
            end
          end
        end
      endcase

      if (move) begin
        // exit actions of the old state
        unique case (state)
          ST_MASTER: begin
            ctl_oos_next = 1'b1;
            res.control_cmd = CT_OOS;
            res.clock_mode_cmd = CM_HOLD;
            res.release_mastership = 1'b1;
          end
          ST_SLAVE: res.clock_mode_cmd = CM_HOLD;
          ST_HOLD: begin
            to_run_next = 1'b0;
            ho_run_next = 1'b0;
          end
          ST_INIT: ;
        endcase
        // entry actions of the new state
        unique case (state_next)
          ST_MASTER: begin
            res.auto_switch_cmd = AS_ENABLE;
            res.clock_mode_cmd  = CM_MASTER;
          end
          ST_SLAVE: begin
            res.auto_switch_cmd = item.card_in_service ? AS_ENABLE : AS_DISABLE;
            res.clock_mode_cmd  = CM_SLAVE;
          end
          ST_HOLD: begin
            to_run_next = 1'b1; to_cnt_next = '0;
            ho_run_next = 1'b1; ho_cnt_next = '0;
          end
          ST_INIT: ;
        endcase
      end
      res.mode_notify = !cfg.auto_update && (state_next != ST_INIT);
    end
    res.fsm_state = state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_INIT;
      to_cnt  <= '0;
      ho_cnt  <= '0;
      to_run  <= 1'b0;
      ho_run  <= 1'b0;
      ctl_oos <= 1'b0;
    end else if (step_en) begin
      state   <= state_next;
      to_cnt  <= to_cnt_next;
      ho_cnt  <= ho_cnt_next;
      to_run  <= to_run_next;
      ho_run  <= ho_run_next;
      ctl_oos <= ctl_oos_next;
    end
  end

  `TRC_ASSERT_IMP(a_timers_paired, clk, rst, 1'b1, to_run == ho_run)
  `TRC_ASSERT_IMP(a_timers_in_hold, clk, rst, to_run, state == ST_HOLD)
  `TRC_ASSERT_NXT(a_tick_keeps_state, clk, rst, step_en && item.operation == OP_TICK,
                  $stable(state))

endmodule
`default_nettype wire

// ===== hw/rtl/timing_redundancy_controller_core.sv =====
// Top level of the timing redundancy controller: streaming ports, request and result registers.
// An accepted request waits in the request register until the result register is free, then
// moves to m_tdata as the state machine and timers step; one request per cycle unless stalled.
// The result register and request register let a request enter while a result waits.
// Reset (rst, synchronous): state init, timers stopped and cleared, registers at defaults.
`default_nettype none
`include "timing_redundancy_controller_core_assert.svh"
module timing_redundancy_controller_core
  import trc_pkg::*;
#(
  parameter int TIMER_BITS = TRC_TIMER_BITS
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [1:0] configured_mode, [2] switch_required, [3] config_changed,
  // [4] card_in_service, [5] is_master, [6] mate_is_master, [7] mate_ready,
  // [8] mate_present, [10:9] mate_clock_mode, [11] local_mode_slave
  input  wire logic [15:0] s_tdata,
  // [0] operation
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [1:0] fsm_state, [3:2] clock_mode_cmd, [5:4] auto_switch_cmd,
  // [7:6] control_cmd, [8] acquire_mastership, [9] release_mastership,
  // [11:10] announce, [12] read_tx_ssm, [13] mode_notify
  output logic [15:0]      m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_t    cfg;
  item_t   item_in, item;
  result_t res;
  logic    in_valid;
  logic    adv;

  // refuse writes while in reset
  assign cfg_ready = !rst;

  trc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  always_comb begin
    item_in.operation        = s_tuser;
    item_in.configured_mode  = s_tdata[1:0];
    item_in.switch_required  = s_tdata[2];
    item_in.config_changed   = s_tdata[3];
    item_in.card_in_service  = s_tdata[4];
    item_in.is_master        = s_tdata[5];
    item_in.mate_is_master   = s_tdata[6];
    item_in.mate_ready       = s_tdata[7];
    item_in.mate_present     = s_tdata[8];
    item_in.mate_clock_mode  = s_tdata[10:9];
    item_in.local_mode_slave = s_tdata[11];
  end

  // advance the held request into the result register when it is free
  assign adv      = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !rst && (!in_valid || adv);

  trc_fsm #(
    .TIMER_BITS (TIMER_BITS)
  ) u_fsm (
    .clk     (clk),
    .rst     (rst),
    .step_en (adv),
    .item    (item),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) in_valid <= 1'b1;
      else if (adv)             in_valid <= 1'b0;
      if (adv)           m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
    if (s_tvalid && s_tready) item <= item_in;
    if (adv) begin
      m_tdata <= {2'b00, res.mode_notify, res.read_tx_ssm, res.announce,
                  res.release_mastership, res.acquire_mastership, res.control_cmd,
                  res.auto_switch_cmd, res.clock_mode_cmd, res.fsm_state};
    end
  end

  `TRC_ASSERT_IMP(a_stall_blocks_input, clk, rst, in_valid && m_tvalid && !m_tready,
                  !s_tready)
  `TRC_ASSERT_NXT(a_step_gives_result, clk, rst, adv, m_tvalid)
  `TRC_ASSERT_NXT(a_result_held, clk, rst, m_tvalid && !m_tready,
                  m_tvalid && $stable(m_tdata))

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for timing_redundancy_controller_core with a scoreboard and a predictor.
`timescale 1ns / 1ps

import trc_pkg::*;

localparam logic [1:0] FSM_INIT   = 2'd0;
localparam logic [1:0] FSM_MASTER = 2'd1;
localparam logic [1:0] FSM_SLAVE  = 2'd2;
localparam logic [1:0] FSM_HOLD   = 2'd3;

localparam logic [1:0] MODE_UNUSED = 2'd3;
localparam logic [1:0] MCM_OTHER   = 2'd3;

class redundancy_scoreboard;
  logic [15:0] timeout_ticks;
  logic [15:0] holdoff_ticks;
  logic        sw_on_timeout;
  logic        auto_update;
  logic [1:0]  fsm;
  logic [15:0] timeout_cnt;
  logic [15:0] holdoff_cnt;
  logic        timeout_run;
  logic        holdoff_run;
  logic        oos_flag;
  result_t     expected_reports[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned ticks;
  int unsigned evals;
  int unsigned moves;
  int unsigned state_hits[4];

  function new();
    timeout_ticks = TRC_TIMEOUT_RESET;
    holdoff_ticks = TRC_HOLDOFF_RESET;
    sw_on_timeout = 1'b1;
    auto_update   = 1'b0;
    fsm           = FSM_INIT;
    timeout_cnt   = '0;
    holdoff_cnt   = '0;
    timeout_run   = 1'b0;
    holdoff_run   = 1'b0;
    oos_flag      = 1'b0;
    errors = 0;
    checked = 0;
    ticks = 0;
    evals = 0;
    moves = 0;
    foreach (state_hits[i]) state_hits[i] = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      REG_TIMEOUT:  timeout_ticks = val;
      REG_HOLDOFF:  holdoff_ticks = val;
      REG_SW_ON_TO: sw_on_timeout = val[0];
      REG_AUTO_UPD: auto_update = val[0];
      default: ;
    endcase
  endfunction

  function logic [1:0] mark_service(bit oos);
    oos_flag = oos;
    return oos ? CT_OOS : CT_INSV;
  endfunction

  function result_t step_controller(item_t r);
    result_t    o;
    logic [1:0] nxt;
    bit         move;
    bit         m_cfg;
    bit         s_cfg;
    bit         to_exp;
    bit         ho_exp;
    o = '0;
    if (r.operation == OP_TICK) begin
      ticks++;
      if (timeout_run && timeout_cnt != '1) timeout_cnt++;
      if (holdoff_run && holdoff_cnt != '1) holdoff_cnt++;
    end else begin
      evals++;
      m_cfg = (r.configured_mode == MODE_MASTER);
      s_cfg = (r.configured_mode == MODE_SLAVE);
      move = 1'b0;
      nxt = fsm;
      case (fsm)
        FSM_INIT: begin
          if (m_cfg) begin
            move = 1'b1;
            nxt = FSM_MASTER;
          end else if (s_cfg) begin
            move = 1'b1;
            nxt = FSM_SLAVE;
          end else if (sw_on_timeout) begin
            if (r.card_in_service) o.acquire_mastership = 1'b1;
            o.control_cmd = mark_service(!r.card_in_service);
            o.clock_mode_cmd = CM_HOLD;
            move = 1'b1;
            nxt = FSM_HOLD;
          end else begin
            o.control_cmd = mark_service(!r.card_in_service);
            if (r.local_mode_slave) begin
              if (r.mate_ready) begin
                o.release_mastership = 1'b1;
                move = 1'b1;
                nxt = FSM_SLAVE;
              end else begin
                o.announce = AN_SLAVE;
              end
            end else begin
              if (r.mate_ready) begin
                o.acquire_mastership = 1'b1;
                move = 1'b1;
                nxt = r.is_master ? FSM_MASTER : FSM_SLAVE;
              end else begin
                o.announce = AN_MASTER;
              end
            end
          end
        end
        FSM_MASTER: begin
          o.read_tx_ssm = 1'b1;
          if (!m_cfg && (r.switch_required || r.config_changed)) begin
            move = 1'b1;
            nxt = FSM_HOLD;
          end
        end
        FSM_SLAVE: begin
          o.read_tx_ssm = 1'b1;
          if (!s_cfg) begin
            if (r.card_in_service) begin
              o.auto_switch_cmd = AS_ENABLE;
              if (oos_flag) o.control_cmd = mark_service(1'b0);
              if ((!r.is_master || r.config_changed) && !r.mate_is_master && r.mate_ready)
                o.acquire_mastership = 1'b1;
              if (r.is_master) begin
                move = 1'b1;
                nxt = FSM_HOLD;
              end else begin
                o.clock_mode_cmd = CM_SLAVE;
              end
            end else begin
              o.auto_switch_cmd = AS_DISABLE;
            end
          end
        end
        default: begin
          to_exp = timeout_run && (timeout_cnt >= timeout_ticks);
          ho_exp = holdoff_run && (holdoff_cnt >= holdoff_ticks);
          if (r.is_master) begin
            if ((sw_on_timeout && to_exp) || (sw_on_timeout && r.mate_clock_mode == MCM_SLAVE) ||
                (!sw_on_timeout && ho_exp && r.mate_clock_mode == MCM_SLAVE) || m_cfg ||
                !r.mate_present) begin
              move = 1'b1;
              nxt = FSM_MASTER;
            end
          end else begin
            if ((sw_on_timeout && to_exp) || r.mate_clock_mode == MCM_MASTER ||
                r.mate_clock_mode == MCM_HOLD || s_cfg || !r.mate_present) begin
              move = 1'b1;
              nxt = FSM_SLAVE;
            end
          end
        end
      endcase

      if (move) begin
        moves++;
        // leave the old state, then enter the new one
        case (fsm)
          FSM_MASTER: begin
            o.control_cmd = mark_service(1'b1);
            o.clock_mode_cmd = CM_HOLD;
            o.release_mastership = 1'b1;
          end
          FSM_SLAVE: o.clock_mode_cmd = CM_HOLD;
          FSM_HOLD: begin
            timeout_run = 1'b0;
            holdoff_run = 1'b0;
          end
          default: ;
        endcase
        case (nxt)
          FSM_MASTER: begin
            o.auto_switch_cmd = AS_ENABLE;
            o.clock_mode_cmd = CM_MASTER;
          end
          FSM_SLAVE: begin
            o.auto_switch_cmd = r.card_in_service ? AS_ENABLE : AS_DISABLE;
            o.clock_mode_cmd = CM_SLAVE;
          end
          FSM_HOLD: begin
            timeout_run = 1'b1;
            timeout_cnt = '0;
            holdoff_run = 1'b1;
            holdoff_cnt = '0;
          end
          default: ;
        endcase
        fsm = nxt;
      end
      o.mode_notify = !auto_update && (fsm != FSM_INIT);
    end
    o.fsm_state = fsm;
    state_hits[fsm]++;
    return o;
  endfunction

  function void note_request(item_t r);
    expected_reports.push_back(step_controller(r));
  endfunction

  function int pending();
    return expected_reports.size();
  endfunction

  function void compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 100)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function void check_result(logic [15:0] d);
    result_t exp;
    checked++;
    if (expected_reports.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual %h", $time, d);
      return;
    end
    exp = expected_reports.pop_front();
    compare_field("fsm_state", exp.fsm_state, d[1:0]);
    compare_field("clock_mode_cmd", exp.clock_mode_cmd, d[3:2]);
    compare_field("auto_switch_cmd", exp.auto_switch_cmd, d[5:4]);
    compare_field("control_cmd", exp.control_cmd, d[7:6]);
    compare_field("acquire_mastership", exp.acquire_mastership, d[8]);
    compare_field("release_mastership", exp.release_mastership, d[9]);
    compare_field("announce", exp.announce, d[11:10]);
    compare_field("read_tx_ssm", exp.read_tx_ssm, d[12]);
    compare_field("mode_notify", exp.mode_notify, d[13]);
  endfunction
endclass

module testbench;
  localparam int unsigned QUIET_LIMIT     = 2000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int unsigned sender_idle_pct = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned rx_hold_left = 0;
  int unsigned quiet_cycles = 0;

  redundancy_scoreboard sb = new();

  always #2 clk = ~clk;

  timing_redundancy_controller_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic [15:0] pack_request(item_t r);
    return {4'b0, r.local_mode_slave, r.mate_clock_mode, r.mate_present, r.mate_ready,
            r.mate_is_master, r.is_master, r.card_in_service, r.config_changed,
            r.switch_required, r.configured_mode};
  endfunction

  function automatic item_t eval_req(input logic [1:0] mode, input bit sw, cc, svc, ism, mm,
                                     mr, mp, input logic [1:0] mcm, input bit ls);
    item_t r;
    r.operation        = OP_EVAL;
    r.configured_mode  = mode;
    r.switch_required  = sw;
    r.config_changed   = cc;
    r.card_in_service  = svc;
    r.is_master        = ism;
    r.mate_is_master   = mm;
    r.mate_ready       = mr;
    r.mate_present     = mp;
    r.mate_clock_mode  = mcm;
    r.local_mode_slave = ls;
    return r;
  endfunction

  function automatic item_t tick_req();
    item_t r;
    r = item_t'(13'($urandom));
    r.operation = OP_TICK;
    return r;
  endfunction

  function automatic item_t random_req();
    item_t r;
    r = item_t'(13'($urandom));
    r.operation = ($urandom_range(99) < 55) ? OP_EVAL : OP_TICK;
    if ($urandom_range(99) < 30) begin
      // keep a holdover card waiting on its timers
      r.configured_mode = MODE_AUTO;
      r.switch_required = 1'b0;
      r.config_changed  = 1'b0;
      r.mate_present    = 1'b1;
      r.mate_clock_mode = MCM_OTHER;
    end
    return r;
  endfunction

  task automatic send_req(input item_t r);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= r.operation;
    s_tdata  <= pack_request(r);
    do @(posedge clk); while (!s_tready);
    sb.note_request(r);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic write_settings(input logic [15:0] tmo, hof, input logic sot, au);
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_HOLDOFF, hof);
    write_reg(REG_SW_ON_TO, {15'd0, sot});
    write_reg(REG_AUTO_UPD, {15'd0, au});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int unsigned idle_pct, stall_pct, count,
                           input bit hold_rx, pause_tx);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 3) begin
        if (hold_rx) rx_hold_left = HOLD_OFF_CYCLES;
        if (pause_tx) wait_drained();
      end
      send_req(random_req());
    end
    wait_drained();
  endtask

  // Result side: check accepted results, then pick the next ready level
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata);
      if (rx_hold_left > 0) begin
        m_tready <= 1'b0;
        rx_hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timing_redundancy_controller_core test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Counters are stopped while in init
    send_req(tick_req());
    wait_drained();

    // Stay in init and announce while the mate is not ready
    write_settings(16'd0, 16'd0, 1'b0, 1'b1);
    send_req(eval_req(MODE_AUTO, 0, 0, 1, 0, 0, 0, 1, MCM_MASTER, 1));
    send_req(eval_req(MODE_UNUSED, 1, 1, 0, 1, 1, 0, 0, MCM_OTHER, 0));
    wait_drained();

    // Zero timeout: expired as soon as holdover starts
    write_settings(16'd0, 16'd0, 1'b1, 1'b0);
    send_req(eval_req(MODE_AUTO, 0, 0, 1, 0, 0, 0, 1, MCM_OTHER, 0));
    send_req(tick_req());
    send_req(eval_req(MODE_AUTO, 0, 0, 1, 1, 0, 1, 1, MCM_OTHER, 0));
    send_req(eval_req(MODE_MASTER, 1, 1, 1, 1, 0, 1, 1, MCM_OTHER, 0));
    send_req(eval_req(MODE_AUTO, 0, 1, 1, 1, 0, 1, 1, MCM_OTHER, 0));
    wait_drained();

    // Holdoff rule, then a walk through the slave rules
    write_settings(16'd0, 16'd0, 1'b0, 1'b0);
    send_req(eval_req(MODE_AUTO, 0, 0, 1, 1, 0, 1, 1, MCM_OTHER, 0));
    send_req(eval_req(MODE_AUTO, 0, 0, 1, 1, 0, 1, 1, MCM_SLAVE, 0));
    send_req(eval_req(MODE_AUTO, 1, 0, 0, 1, 0, 1, 1, MCM_OTHER, 0));
    send_req(eval_req(MODE_AUTO, 0, 0, 0, 0, 0, 1, 1, MCM_HOLD, 0));
    send_req(eval_req(MODE_SLAVE, 1, 1, 1, 1, 0, 1, 1, MCM_OTHER, 0));
    send_req(eval_req(MODE_AUTO, 0, 0, 0, 0, 0, 1, 1, MCM_OTHER, 0));
    send_req(eval_req(MODE_AUTO, 0, 0, 1, 0, 0, 1, 1, MCM_OTHER, 0));
    send_req(eval_req(MODE_AUTO, 0, 1, 1, 1, 0, 1, 1, MCM_OTHER, 0));
    send_req(eval_req(MODE_AUTO, 0, 0, 1, 0, 1, 1, 0, MCM_OTHER, 0));
    send_req(eval_req(MODE_UNUSED, 1, 1, 1, 1, 1, 1, 1, MCM_OTHER, 1));
    wait_drained();

    write_settings(16'd3, 16'd5, 1'b1, 1'b0);
    run_phase(0, 0, 300, 1'b0, 1'b0);
    write_settings(16'd0, 16'd0, 1'b0, 1'b1);
    run_phase(60, 0, 300, 1'b0, 1'b0);
    write_settings(16'd1, 16'd1, 1'b0, 1'b0);
    run_phase(0, 60, 300, 1'b0, 1'b0);
    write_settings(16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
    run_phase(7, 7, 300, 1'b1, 1'b0);
    write_settings(16'd10, 16'd20, 1'b0, 1'b0);
    run_phase(7, 7, 300, 1'b0, 1'b1);
    write_settings(16'd2, 16'hFFFF, 1'b1, 1'b0);
    run_phase(0, 0, 200, 1'b0, 1'b0);
    repeat (8) @(posedge clk);

    $display("Covered %0d requests (%0d evaluations, %0d ticks), %0d state changes, %0d results.",
             sb.evals + sb.ticks, sb.evals, sb.ticks, sb.moves, sb.checked);
    $display("Results by state init/master/slave/holdover: %0d/%0d/%0d/%0d.",
             sb.state_hits[FSM_INIT], sb.state_hits[FSM_MASTER], sb.state_hits[FSM_SLAVE],
             sb.state_hits[FSM_HOLD]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("timing_redundancy_controller_core test passed");
    end else begin
      $display("timing_redundancy_controller_core test failed");
    end
    $finish;
  end
endmodule
